// ----- rtl/core/complex_fixed_alu_macros.svh -----
`ifndef COMPLEX_FIXED_ALU_MACROS_SVH
`define COMPLEX_FIXED_ALU_MACROS_SVH

// same-cycle implication, checked while out of reset
`define CFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("complex_fixed_alu check failed");

// next-cycle implication, checked while out of reset
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("complex_fixed_alu check failed");

`endif

// ----- rtl/core/cfa_pkg.sv -----
`timescale 1ns / 1ps

package cfa_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_BITS   = 2 * WORD_BITS;
    localparam int QUOT_BITS   = WORD_BITS + 1;
    localparam int DIV_STEPS   = QUOT_BITS;
    localparam int NUM_BITS    = PROD_BITS + WORD_BITS;
    localparam int SQ_X_BITS   = 2 * QUOT_BITS;
    localparam int SQ_REM_BITS = QUOT_BITS + 3;
    localparam int N_PROD      = 6;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [WORD_BITS:0]   t_lin;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [PROD_BITS:0]   t_wide;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_MUL       = 4'd2,
        OP_DIV       = 4'd3,
        OP_SCALE     = 4'd4,
        OP_DIVREAL   = 4'd5,
        OP_REAL_OVER = 4'd6,
        OP_NEG       = 4'd7,
        OP_CONJ      = 4'd8,
        OP_ABS       = 4'd9,
        OP_RECIP     = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic  ovf;
        t_word val;
    } t_fix;

    // one item on its way through the division / square root steps
    typedef struct packed {
        t_op                    op;
        logic                   dz;
        t_word                  dre;
        t_word                  dim;
        logic                   dovf;
        logic                   re_neg;
        logic                   im_neg;
        logic                   re_big;
        logic                   im_big;
        logic [PROD_BITS-1:0]   re_rem;
        logic [PROD_BITS-1:0]   im_rem;
        logic [QUOT_BITS-1:0]   re_num;
        logic [QUOT_BITS-1:0]   im_num;
        logic [QUOT_BITS-1:0]   re_q;
        logic [QUOT_BITS-1:0]   im_q;
        logic [PROD_BITS-1:0]   den;
        logic [SQ_X_BITS-1:0]   sq_x;
        logic [SQ_REM_BITS-1:0] sq_rem;
        logic [QUOT_BITS-1:0]   sq_root;
    } t_work;

    // clamp a sign/magnitude value to the signed word range
    function automatic t_fix sat_fix(input logic neg, input logic [PROD_BITS-1:0] mag);
        t_fix                 r;
        logic [PROD_BITS-1:0] lim;
        lim   = PROD_BITS'(1) << (WORD_BITS - 1);
        r.ovf = 1'b0;
        if (neg) begin
            if (mag > lim) begin
                r.ovf = 1'b1;
                r.val = t_word'(lim);
            end else begin
                r.val = t_word'(PROD_BITS'(0) - mag);
            end
        end else begin
            if (mag > lim - PROD_BITS'(1)) begin
                r.ovf = 1'b1;
                r.val = t_word'(lim - PROD_BITS'(1));
            end else begin
                r.val = t_word'(mag);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/cfa_if.sv -----
`timescale 1ns / 1ps

interface cfa_in_if;
    import cfa_pkg::*;

    logic        valid;
    logic        ready;
    logic [3:0]  op;
    t_word       a_re;
    t_word       a_im;
    t_word       b_re;
    t_word       b_im;
    t_word       scalar;

    modport source (output valid, output op, output a_re, output a_im, output b_re,
                    output b_im, output scalar, input ready);
    modport sink   (input valid, input op, input a_re, input a_im, input b_re,
                    input b_im, input scalar, output ready);
endinterface

interface cfa_out_if;
    import cfa_pkg::*;

    logic        valid;
    logic        ready;
    t_word       res_re;
    t_word       res_im;
    logic [1:0]  status;

    modport source (output valid, output res_re, output res_im, output status, input ready);
    modport sink   (input valid, input res_re, input res_im, input status, output ready);
endinterface

// ----- rtl/core/complex_fixed_alu.sv -----
`timescale 1ns / 1ps

// Complex arithmetic unit, signed Q16.16. Takes one item per cycle while the output is not
// stalled and returns one result per item, in order, through these stages: operand select,
// six parallel 32x32 multipliers, sums, sign/magnitude and range clamp, divisor range check,
// 33 restoring steps that share each stage between the two quotient lanes and the square
// root, and a saturating output register. Quotients truncate toward zero, the magnitude is the
// floor of the square root. The whole pipe holds while a result waits at the output; the
// input is ready whenever the output register is empty or being taken.
module complex_fixed_alu (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfa_in_if.sink    i_in,
    cfa_out_if.source o_out
);
    import cfa_pkg::*;

    logic en;

    // stage 1: operand select
    t_op   op_in;
    t_word n1_x [N_PROD];
    t_word n1_y [N_PROD];
    t_lin  n1_lin_re;
    t_lin  n1_lin_im;
    logic  r1_valid;
    t_op   r1_op;
    t_word r1_x [N_PROD];
    t_word r1_y [N_PROD];
    t_lin  r1_lin_re;
    t_lin  r1_lin_im;
    t_word r1_ar;
    t_word r1_ai;
    t_word r1_s;

    // stage 2: products
    logic  r2_valid;
    t_op   r2_op;
    t_prod r2_p [N_PROD];
    t_lin  r2_lin_re;
    t_lin  r2_lin_im;
    t_word r2_ar;
    t_word r2_ai;
    t_word r2_s;

    // stage 3: sums
    t_wide                n3_re;
    t_wide                n3_im;
    logic [PROD_BITS-1:0] n3_den;
    t_wide                s_abs;
    logic                 r3_valid;
    t_op                  r3_op;
    t_wide                r3_re;
    t_wide                r3_im;
    logic [PROD_BITS-1:0] r3_den;
    logic                 r3_dneg;

    // stage 4: sign/magnitude
    t_wide                re_abs;
    t_wide                im_abs;
    logic                 re_neg;
    logic                 im_neg;
    logic [PROD_BITS-1:0] re_mag;
    logic [PROD_BITS-1:0] im_mag;
    t_fix                 re_dir;
    t_fix                 im_dir;
    logic [NUM_BITS-1:0]  re_n;
    logic [NUM_BITS-1:0]  im_n;
    t_work                n4_work;
    logic                 r4_valid;
    t_work                r4_work;

    // stage 5: divisor range check
    t_work n5_work;
    logic  r5_valid;
    t_work r5_work;

    logic  w_valid [DIV_STEPS+1];
    t_work w_work  [DIV_STEPS+1];

    // output
    t_work                wf;
    logic [PROD_BITS-1:0] q_re_mag;
    logic [PROD_BITS-1:0] q_im_mag;
    t_fix                 fq_re;
    t_fix                 fq_im;
    t_fix                 f_root;
    t_word                n_out_re;
    t_word                n_out_im;
    t_status              n_out_status;
    logic                 r_out_valid;
    t_word                r_out_re;
    t_word                r_out_im;
    t_status              r_out_status;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        op_in     = t_op'(i_in.op);
        n1_lin_re = '0;
        n1_lin_im = '0;
        for (int k = 0; k < N_PROD; k++) begin
            n1_x[k] = '0;
            n1_y[k] = '0;
        end
        case (op_in)
            OP_ADD: begin
                n1_lin_re = t_lin'(i_in.a_re) + t_lin'(i_in.b_re);
                n1_lin_im = t_lin'(i_in.a_im) + t_lin'(i_in.b_im);
            end
            OP_SUB: begin
                n1_lin_re = t_lin'(i_in.a_re) - t_lin'(i_in.b_re);
                n1_lin_im = t_lin'(i_in.a_im) - t_lin'(i_in.b_im);
            end
            OP_NEG: begin
                n1_lin_re = t_lin'(0) - t_lin'(i_in.a_re);
                n1_lin_im = t_lin'(0) - t_lin'(i_in.a_im);
            end
            OP_CONJ: begin
                n1_lin_re = t_lin'(i_in.a_re);
                n1_lin_im = t_lin'(0) - t_lin'(i_in.a_im);
            end
            OP_MUL, OP_DIV: begin
                n1_x[0] = i_in.a_re;  n1_y[0] = i_in.b_re;
                n1_x[1] = i_in.a_im;  n1_y[1] = i_in.b_im;
                n1_x[2] = i_in.a_im;  n1_y[2] = i_in.b_re;
                n1_x[3] = i_in.a_re;  n1_y[3] = i_in.b_im;
                n1_x[4] = i_in.b_re;  n1_y[4] = i_in.b_re;
                n1_x[5] = i_in.b_im;  n1_y[5] = i_in.b_im;
            end
            OP_SCALE: begin
                n1_x[0] = i_in.a_re;  n1_y[0] = i_in.scalar;
                n1_x[2] = i_in.a_im;  n1_y[2] = i_in.scalar;
            end
            OP_REAL_OVER: begin
                n1_x[0] = i_in.scalar;  n1_y[0] = i_in.b_re;
                n1_x[3] = i_in.scalar;  n1_y[3] = i_in.b_im;
                n1_x[4] = i_in.b_re;    n1_y[4] = i_in.b_re;
                n1_x[5] = i_in.b_im;    n1_y[5] = i_in.b_im;
            end
            OP_ABS, OP_RECIP: begin
                n1_x[4] = i_in.a_re;  n1_y[4] = i_in.a_re;
                n1_x[5] = i_in.a_im;  n1_y[5] = i_in.a_im;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op     <= op_in;
            r1_x      <= n1_x;
            r1_y      <= n1_y;
            r1_lin_re <= n1_lin_re;
            r1_lin_im <= n1_lin_im;
            r1_ar     <= i_in.a_re;
            r1_ai     <= i_in.a_im;
            r1_s      <= i_in.scalar;

            r2_op     <= r1_op;
            for (int k = 0; k < N_PROD; k++) begin
                r2_p[k] <= r1_x[k] * r1_y[k];
            end
            r2_lin_re <= r1_lin_re;
            r2_lin_im <= r1_lin_im;
            r2_ar     <= r1_ar;
            r2_ai     <= r1_ai;
            r2_s      <= r1_s;

            r3_op     <= r2_op;
            r3_re     <= n3_re;
            r3_im     <= n3_im;
            r3_den    <= n3_den;
            r3_dneg   <= (r2_op == OP_DIVREAL) && (r2_s < 0);

            r4_work   <= n4_work;
            r5_work   <= n5_work;
        end
    end

    always_comb begin
        n3_re  = '0;
        n3_im  = '0;
        n3_den = '0;
        s_abs  = (r2_s < 0) ? (t_wide'(0) - t_wide'(r2_s)) : t_wide'(r2_s);
        case (r2_op)
            OP_ADD, OP_SUB, OP_NEG, OP_CONJ: begin
                n3_re = t_wide'(r2_lin_re);
                n3_im = t_wide'(r2_lin_im);
            end
            OP_MUL, OP_SCALE: begin
                n3_re = t_wide'(r2_p[0]) - t_wide'(r2_p[1]);
                n3_im = t_wide'(r2_p[2]) + t_wide'(r2_p[3]);
            end
            OP_DIV, OP_REAL_OVER: begin
                n3_re  = t_wide'(r2_p[0]) + t_wide'(r2_p[1]);
                n3_im  = t_wide'(r2_p[2]) - t_wide'(r2_p[3]);
                n3_den = $unsigned(r2_p[4]) + $unsigned(r2_p[5]);
            end
            OP_DIVREAL: begin
                n3_re  = t_wide'(r2_ar);
                n3_im  = t_wide'(r2_ai);
                n3_den = s_abs[PROD_BITS-1:0];
            end
            OP_ABS: begin
                n3_den = $unsigned(r2_p[4]) + $unsigned(r2_p[5]);
            end
            OP_RECIP: begin
                n3_re  = t_wide'(r2_ar);
                n3_im  = t_wide'(0) - t_wide'(r2_ai);
                n3_den = $unsigned(r2_p[4]) + $unsigned(r2_p[5]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        re_neg = r3_re < 0;
        im_neg = r3_im < 0;
        re_abs = re_neg ? (t_wide'(0) - r3_re) : r3_re;
        im_abs = im_neg ? (t_wide'(0) - r3_im) : r3_im;
        re_mag = re_abs[PROD_BITS-1:0];
        im_mag = im_abs[PROD_BITS-1:0];

        // products drop their fraction bits toward zero
        if (r3_op inside {OP_MUL, OP_SCALE}) begin
            re_dir = sat_fix(re_neg, re_mag >> FRAC_BITS);
            im_dir = sat_fix(im_neg, im_mag >> FRAC_BITS);
        end else begin
            re_dir = sat_fix(re_neg, re_mag);
            im_dir = sat_fix(im_neg, im_mag);
        end

        if (r3_op == OP_RECIP) begin
            re_n = NUM_BITS'(re_mag) << (2 * FRAC_BITS);
            im_n = NUM_BITS'(im_mag) << (2 * FRAC_BITS);
        end else begin
            re_n = NUM_BITS'(re_mag) << FRAC_BITS;
            im_n = NUM_BITS'(im_mag) << FRAC_BITS;
        end

        n4_work         = '0;
        n4_work.op      = r3_op;
        n4_work.dre     = re_dir.val;
        n4_work.dim     = im_dir.val;
        n4_work.dovf    = re_dir.ovf | im_dir.ovf;
        n4_work.re_neg  = re_neg ^ r3_dneg;
        n4_work.im_neg  = im_neg ^ r3_dneg;
        n4_work.re_rem  = PROD_BITS'(re_n[NUM_BITS-1:QUOT_BITS]);
        n4_work.im_rem  = PROD_BITS'(im_n[NUM_BITS-1:QUOT_BITS]);
        n4_work.re_num  = re_n[QUOT_BITS-1:0];
        n4_work.im_num  = im_n[QUOT_BITS-1:0];
        n4_work.den     = r3_den;
        n4_work.sq_x    = SQ_X_BITS'(r3_den);
        n4_work.dz      = (r3_op inside {OP_DIV, OP_REAL_OVER, OP_DIVREAL, OP_RECIP})
                          && (r3_den == '0);
    end

    // a quotient that would not fit the step count saturates anyway
    always_comb begin
        n5_work        = r4_work;
        n5_work.re_big = r4_work.re_rem >= r4_work.den;
        n5_work.im_big = r4_work.im_rem >= r4_work.den;
    end

    assign w_valid[0] = r5_valid;
    assign w_work[0]  = r5_work;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        cfa_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_work  (w_work[g]),
            .o_valid (w_valid[g+1]),
            .o_work  (w_work[g+1])
        );
    end

    always_comb begin
        wf       = w_work[DIV_STEPS];
        q_re_mag = wf.re_big ? '1 : PROD_BITS'(wf.re_q);
        q_im_mag = wf.im_big ? '1 : PROD_BITS'(wf.im_q);
        fq_re    = sat_fix(wf.re_neg, q_re_mag);
        fq_im    = sat_fix(wf.im_neg, q_im_mag);
        f_root   = sat_fix(1'b0, PROD_BITS'(wf.sq_root));
        case (wf.op)
            OP_DIV, OP_REAL_OVER, OP_DIVREAL, OP_RECIP: begin
                if (wf.dz) begin
                    n_out_re     = '0;
                    n_out_im     = '0;
                    n_out_status = ST_DIV_ZERO;
                end else begin
                    n_out_re     = fq_re.val;
                    n_out_im     = fq_im.val;
                    n_out_status = (fq_re.ovf || fq_im.ovf) ? ST_OVERFLOW : ST_OK;
                end
            end
            OP_ABS: begin
                n_out_re     = f_root.val;
                n_out_im     = '0;
                n_out_status = f_root.ovf ? ST_OVERFLOW : ST_OK;
            end
            default: begin
                n_out_re     = wf.dre;
                n_out_im     = wf.dim;
                n_out_status = wf.dovf ? ST_OVERFLOW : ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_re     <= n_out_re;
            r_out_im     <= n_out_im;
            r_out_status <= n_out_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.res_re = r_out_re;
    assign o_out.res_im = r_out_im;
    assign o_out.status = r_out_status;

endmodule

// ----- rtl/core/cfa_step.sv -----
`timescale 1ns / 1ps

module cfa_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cfa_pkg::t_work i_work,
    output logic           o_valid,
    output cfa_pkg::t_work o_work
);
    import cfa_pkg::*;

    logic [PROD_BITS:0]   den_x;
    logic [PROD_BITS:0]   re_sh;
    logic [PROD_BITS:0]   im_sh;
    logic [PROD_BITS:0]   re_diff;
    logic [PROD_BITS:0]   im_diff;
    logic [SQ_REM_BITS-1:0] sq_cur;
    logic [SQ_REM_BITS-1:0] sq_trial;
    t_work                n_work;
    t_work                r_work;
    logic                 r_valid;

    always_comb begin
        n_work  = i_work;
        den_x   = {1'b0, i_work.den};

        // one restoring division step per lane
        re_sh   = {i_work.re_rem, i_work.re_num[QUOT_BITS-1]};
        im_sh   = {i_work.im_rem, i_work.im_num[QUOT_BITS-1]};
        re_diff = re_sh - den_x;
        im_diff = im_sh - den_x;
        if (re_sh >= den_x) begin
            n_work.re_rem = re_diff[PROD_BITS-1:0];
            n_work.re_q   = {i_work.re_q[QUOT_BITS-2:0], 1'b1};
        end else begin
            n_work.re_rem = re_sh[PROD_BITS-1:0];
            n_work.re_q   = {i_work.re_q[QUOT_BITS-2:0], 1'b0};
        end
        if (im_sh >= den_x) begin
            n_work.im_rem = im_diff[PROD_BITS-1:0];
            n_work.im_q   = {i_work.im_q[QUOT_BITS-2:0], 1'b1};
        end else begin
            n_work.im_rem = im_sh[PROD_BITS-1:0];
            n_work.im_q   = {i_work.im_q[QUOT_BITS-2:0], 1'b0};
        end
        n_work.re_num = {i_work.re_num[QUOT_BITS-2:0], 1'b0};
        n_work.im_num = {i_work.im_num[QUOT_BITS-2:0], 1'b0};

        // one digit of the integer square root
        sq_cur   = {i_work.sq_rem[SQ_REM_BITS-3:0], i_work.sq_x[SQ_X_BITS-1 -: 2]};
        sq_trial = {1'b0, i_work.sq_root, 2'b01};
        if (sq_cur >= sq_trial) begin
            n_work.sq_rem  = sq_cur - sq_trial;
            n_work.sq_root = {i_work.sq_root[QUOT_BITS-2:0], 1'b1};
        end else begin
            n_work.sq_rem  = sq_cur;
            n_work.sq_root = {i_work.sq_root[QUOT_BITS-2:0], 1'b0};
        end
        n_work.sq_x = {i_work.sq_x[SQ_X_BITS-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// ----- rtl/core/cfa_checker.sv -----
`timescale 1ns / 1ps

`include "complex_fixed_alu_macros.svh"

module cfa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input cfa_pkg::t_word i_res_re,
    input cfa_pkg::t_word i_res_im,
    input logic [1:0]     i_status
);
    import cfa_pkg::*;

    localparam t_word WORD_MAX = t_word'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam t_word WORD_MIN = t_word'({1'b1, {(WORD_BITS-1){1'b0}}});

    // a zero divisor always gives a zero result
    `CFA_ASSERT_NOW(a_dz_zero, i_clk, i_rst_n, i_out_valid && i_status == ST_DIV_ZERO, i_res_re == '0 && i_res_im == '0)

    // saturation leaves at least one part on a bound
    `CFA_ASSERT_NOW(a_ovf_bound, i_clk, i_rst_n, i_out_valid && i_status == ST_OVERFLOW, i_res_re == WORD_MAX || i_res_re == WORD_MIN || i_res_im == WORD_MAX || i_res_im == WORD_MIN)

    // a stalled result stays put
    `CFA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_res_re) && $stable(i_res_im) && $stable(i_status))

endmodule

bind complex_fixed_alu cfa_checker u_cfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_re    (o_out.res_re),
    .i_res_im    (o_out.res_im),
    .i_status    (o_out.status)
);

// ----- sim/tb_complex_fixed_alu.sv -----
`timescale 1ns / 1ps

module tb_complex_fixed_alu;
    import cfa_pkg::*;

    typedef struct {
        bit          neg;
        bit [63:0]   mag;
    } t_sm;

    typedef struct {
        t_word   re;
        t_word   im;
        t_status st;
    } t_result;

    localparam logic [31:0] W_MAX = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] W_ONE = 32'h0001_0000;

    logic i_clk;
    logic i_rst_n;

    cfa_in_if  in_if ();
    cfa_out_if out_if ();

    complex_fixed_alu uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_result result_q[$];
    int      n_err;
    int      n_sent;
    int      n_checked;
    int      snd_idle_pct;
    int      rcv_idle_pct;
    int      rcv_hold;

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- arithmetic
    function automatic t_sm mk(bit neg, bit [63:0] mag);
        t_sm r;
        r.neg = neg && (mag != 0);
        r.mag = mag;
        return r;
    endfunction

    function automatic t_sm from_int(longint v);
        return mk(v < 0, v < 0 ? 64'(-v) : 64'(v));
    endfunction

    function automatic t_sm smul(longint x, longint y);
        t_sm p;
        t_sm q;
        p = from_int(x);
        q = from_int(y);
        return mk(p.neg != q.neg, p.mag * q.mag);
    endfunction

    function automatic t_sm sneg(t_sm v);
        return mk(!v.neg, v.mag);
    endfunction

    function automatic t_sm sadd(t_sm p, t_sm q);
        if (p.neg == q.neg) return mk(p.neg, p.mag + q.mag);
        if (p.mag >= q.mag) return mk(p.neg, p.mag - q.mag);
        return mk(q.neg, q.mag - p.mag);
    endfunction

    function automatic t_sm sshr(t_sm v);
        return mk(v.neg, v.mag >> FRAC_BITS);
    endfunction

    // sum of two squares, exact in 64 bits
    function automatic bit [63:0] sum_sq(longint x, longint y);
        t_sm p;
        t_sm q;
        p = smul(x, x);
        q = smul(y, y);
        return p.mag + q.mag;
    endfunction

    // truncating quotient of (num << sh) / den, huge quotients pin to all ones
    function automatic t_sm sdiv(t_sm num, int sh, bit [63:0] den, bit dneg);
        bit [127:0] n;
        bit [127:0] q;
        n = {64'd0, num.mag} << sh;
        q = n / {64'd0, den};
        return mk(num.neg != dneg, (q[127:41] != 0) ? 64'hffff_ffff_ffff_ffff : q[63:0]);
    endfunction

    function automatic t_word clamp(t_sm v, inout bit ovf);
        if (v.neg) begin
            if (v.mag > 64'h8000_0000) begin
                ovf = 1'b1;
                return W_MIN;
            end
            return t_word'(64'd0 - v.mag);
        end
        if (v.mag > 64'h7fff_ffff) begin
            ovf = 1'b1;
            return W_MAX;
        end
        return t_word'(v.mag);
    endfunction

    function automatic t_result alu_result(logic [3:0] op, t_word a_re, t_word a_im,
                                           t_word b_re, t_word b_im, t_word sc);
        longint    ar;
        longint    ai;
        longint    br;
        longint    bi;
        longint    s;
        t_sm       re;
        t_sm       im;
        t_sm       s_sm;
        bit        dz;
        bit        ovf;
        bit [63:0] d;
        bit [63:0] x;
        bit [63:0] root;
        bit [63:0] bt;
        t_result   r;
        ar = a_re; ai = a_im; br = b_re; bi = b_im; s = sc;
        re = mk(0, 0);
        im = mk(0, 0);
        dz = 0;
        ovf = 0;
        case (op)
            OP_ADD: begin re = from_int(ar + br); im = from_int(ai + bi); end
            OP_SUB: begin re = from_int(ar - br); im = from_int(ai - bi); end
            OP_MUL: begin
                re = sshr(sadd(smul(ar, br), sneg(smul(ai, bi))));
                im = sshr(sadd(smul(ai, br), smul(ar, bi)));
            end
            OP_DIV: begin
                d = sum_sq(br, bi);
                if (d == 0) dz = 1;
                else begin
                    re = sdiv(sadd(smul(ar, br), smul(ai, bi)), FRAC_BITS, d, 0);
                    im = sdiv(sadd(smul(ai, br), sneg(smul(ar, bi))), FRAC_BITS, d, 0);
                end
            end
            OP_SCALE: begin re = sshr(smul(ar, s)); im = sshr(smul(ai, s)); end
            OP_DIVREAL: begin
                if (s == 0) dz = 1;
                else begin
                    s_sm = from_int(s);
                    re = sdiv(from_int(ar), FRAC_BITS, s_sm.mag, s < 0);
                    im = sdiv(from_int(ai), FRAC_BITS, s_sm.mag, s < 0);
                end
            end
            OP_REAL_OVER: begin
                d = sum_sq(br, bi);
                if (d == 0) dz = 1;
                else begin
                    re = sdiv(smul(s, br), FRAC_BITS, d, 0);
                    im = sdiv(sneg(smul(s, bi)), FRAC_BITS, d, 0);
                end
            end
            OP_NEG:  begin re = from_int(-ar); im = from_int(-ai); end
            OP_CONJ: begin re = from_int(ar); im = from_int(-ai); end
            OP_ABS: begin
                // floor square root, bit by bit
                x = sum_sq(ar, ai);
                root = 0;
                bt = 64'd1 << 62;
                while (bt > x) bt = bt >> 2;
                while (bt != 0) begin
                    if (x >= root + bt) begin
                        x = x - (root + bt);
                        root = (root >> 1) + bt;
                    end else begin
                        root = root >> 1;
                    end
                    bt = bt >> 2;
                end
                re = mk(0, root);
            end
            OP_RECIP: begin
                d = sum_sq(ar, ai);
                if (d == 0) dz = 1;
                else begin
                    re = sdiv(from_int(ar), 2 * FRAC_BITS, d, 0);
                    im = sdiv(from_int(-ai), 2 * FRAC_BITS, d, 0);
                end
            end
            default: ;
        endcase
        r.re = clamp(re, ovf);
        r.im = clamp(im, ovf);
        if (dz) begin
            r.re = 0;
            r.im = 0;
        end
        r.st = dz ? ST_DIV_ZERO : (ovf ? ST_OVERFLOW : ST_OK);
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.re = out_if.res_re;
            got.im = out_if.res_im;
            got.st = t_status'(out_if.status);
            if (result_q.size() == 0) begin
                $error("unexpected result re=%h im=%h status=%0d", got.re, got.im, got.st);
                n_err++;
            end else begin
                want = result_q.pop_front();
                n_checked++;
                if (got.re !== want.re) begin
                    $error("res_re expected %h actual %h", want.re, got.re);
                    n_err++;
                end
                if (got.im !== want.im) begin
                    $error("res_im expected %h actual %h", want.im, got.im);
                    n_err++;
                end
                if (got.st !== want.st) begin
                    $error("status expected %0d actual %0d", want.st, out_if.status);
                    n_err++;
                end
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            result_q.push_back(alu_result(in_if.op, in_if.a_re, in_if.a_im,
                                          in_if.b_re, in_if.b_im, in_if.scalar));
            n_sent++;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (rcv_hold > 0) begin
            out_if.ready <= 1'b0;
            rcv_hold     <= rcv_hold - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus
    // entered and left at a falling edge
    task automatic send_item(logic [3:0] op, t_word a_re, t_word a_im, t_word b_re,
                             t_word b_im, t_word sc);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid  = 1'b1;
        in_if.op     = op;
        in_if.a_re   = a_re;
        in_if.a_im   = a_im;
        in_if.b_re   = b_re;
        in_if.b_im   = b_im;
        in_if.scalar = sc;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (result_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(5))
            0, 1: return t_word'($urandom);
            2: return t_word'(int'($urandom_range(32'h0008_0000)) - 32'h0004_0000);
            3: return t_word'(int'($urandom_range(32'h0000_0400)) - 32'h0000_0200);
            4: begin
                case ($urandom_range(3))
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return W_ONE;
                    default: return t_word'(-int'(W_ONE));
                endcase
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic [3:0] rand_op();
        if ($urandom_range(99) < 5) return 4'($urandom_range(15, 11));
        return 4'($urandom_range(OP_RECIP));
    endfunction

    task automatic test_directed();
        send_item(OP_ADD, W_MAX, W_MIN, W_MAX, W_MIN, 0);
        send_item(OP_SUB, W_MIN, W_MAX, W_MAX, W_MIN, 0);
        send_item(OP_ADD, W_ONE, -W_ONE, W_ONE, W_ONE, 0);
        send_item(OP_MUL, W_MIN, W_MIN, W_MIN, W_MIN, 0);
        send_item(OP_MUL, W_ONE, W_ONE, W_ONE, -W_ONE, 0);
        send_item(OP_DIV, W_MAX, W_MIN, 1, 0, 0);
        send_item(OP_DIV, W_ONE, W_ONE, 0, 0, 0);
        send_item(OP_DIV, W_ONE, 3 * W_ONE, W_ONE, -W_ONE, 0);
        send_item(OP_SCALE, W_MAX, W_MIN, 0, 0, W_MIN);
        send_item(OP_SCALE, W_ONE, -W_ONE, 0, 0, 32'h0000_8000);
        send_item(OP_DIVREAL, W_ONE, W_MIN, 0, 0, 0);
        send_item(OP_DIVREAL, W_MIN, W_MAX, 0, 0, -1);
        send_item(OP_REAL_OVER, 0, 0, 0, 0, W_ONE);
        send_item(OP_REAL_OVER, 0, 0, 1, -1, W_MIN);
        send_item(OP_NEG, W_MIN, W_MAX, 0, 0, 0);
        send_item(OP_CONJ, W_MAX, W_MIN, 0, 0, 0);
        send_item(OP_ABS, W_MIN, W_MIN, 0, 0, 0);
        send_item(OP_ABS, 3 * W_ONE, 4 * W_ONE, 0, 0, 0);
        send_item(OP_RECIP, 0, 0, 0, 0, 0);
        send_item(OP_RECIP, 1, 0, 0, 0, 0);
        send_item(OP_RECIP, W_MAX, W_MIN, 0, 0, 0);
        send_item(4'd11, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
        send_item(4'd15, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
        wait_drained();
    endtask

    task automatic test_random(int n);
        logic [3:0] op;
        t_word      b_re;
        t_word      b_im;
        t_word      sc;
        repeat (n) begin
            op   = rand_op();
            b_re = rand_word();
            b_im = rand_word();
            sc   = rand_word();
            // keep zero divisors coming now and then
            if ($urandom_range(99) < 5) begin
                b_re = 0;
                b_im = 0;
                sc   = 0;
            end
            send_item(op, rand_word(), rand_word(), b_re, b_im, sc);
        end
    endtask

    task automatic test_backpressure();
        int save;
        save = snd_idle_pct;
        snd_idle_pct = 0;
        @(posedge i_clk);
        rcv_hold = 300;
        @(negedge i_clk);
        test_random(90);
        snd_idle_pct = save;
    endtask

    task automatic test_pause_drain();
        test_random(30);
        wait_drained();
        repeat (60) @(negedge i_clk);
        test_random(30);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.op      = '0;
        in_if.a_re    = '0;
        in_if.a_im    = '0;
        in_if.b_re    = '0;
        in_if.b_im    = '0;
        in_if.scalar  = '0;
        out_if.ready  = 1'b0;
        n_err         = 0;
        n_sent        = 0;
        n_checked     = 0;
        rcv_hold      = 0;
        snd_idle_pct  = 10;
        rcv_idle_pct  = 71;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(250);
        test_pause_drain();

        snd_idle_pct = 71;
        rcv_idle_pct = 10;
        test_random(220);
        test_backpressure();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(200);

        wait_drained();
        repeat (60) @(negedge i_clk);
        $display("%0d items sent, %0d results checked: all op codes, zero divisors, saturation,",
                 n_sent, n_checked);
        $display("random stalls on both sides, a long output hold-off and a full drain");
        if (n_err == 0 && result_q.size() == 0) begin
            $display("tb_complex_fixed_alu passed");
        end else begin
            $display("tb_complex_fixed_alu failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_complex_fixed_alu failed");
        $finish;
    end

endmodule

// ----- complex_fixed_alu.f -----
+incdir+rtl/core
rtl/core/cfa_pkg.sv
rtl/core/cfa_if.sv
rtl/core/cfa_step.sv
rtl/core/complex_fixed_alu.sv
rtl/core/cfa_checker.sv
sim/tb_complex_fixed_alu.sv
